// ===== hdl/assert_macros.svh =====
// Assertion macros for the RTL, included by the top-level module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define MBF_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition implies another one on the next clock edge.
`define MBF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/mbf_pkg.sv =====
// Shared constants and types of the mipmap box filter generator.
package mbf_pkg;

	localparam int MAX_SIZE_LOG2 = 10;
	localparam int CHANNEL_BITS  = 16;
	localparam int LOG_W         = 4;                  // width of a size register
	localparam int LEV_W         = $clog2(MAX_SIZE_LOG2);
	localparam int POS_W         = MAX_SIZE_LOG2;      // level-0 column / row
	localparam int TXY_W         = POS_W - 1;          // coordinate at level 1 and up
	localparam int CHAIN_W       = 21;
	localparam int ROW_AW        = MAX_SIZE_LOG2;
	localparam int ROW_DEPTH     = 1 << ROW_AW;
	localparam int PAIR_W        = CHANNEL_BITS + 1;
	localparam int SUM_W         = CHANNEL_BITS + 3;   // block sum plus rounding

	localparam logic CFG_WIDTH  = 1'b0;
	localparam logic CFG_HEIGHT = 1'b1;

	typedef logic [CHANNEL_BITS-1:0] chan_t;
	typedef logic [PAIR_W-1:0]       pchan_t;

	typedef struct packed {
		chan_t r;
		chan_t g;
		chan_t b;
	} rgb_t;

	typedef struct packed {
		pchan_t r;
		pchan_t g;
		pchan_t b;
	} pair_t;

	// Frame geometry after clamping.
	typedef struct packed {
		logic [LOG_W-1:0] wl;
		logic [LOG_W-1:0] hl;
		logic [LOG_W-1:0] levels;
	} geom_t;

	// Access to the row store of pair sums.
	typedef struct packed {
		logic              en;
		logic              we;
		logic [ROW_AW-1:0] addr;
		pair_t             wdata;
	} row_req_t;

	typedef struct packed {
		logic [LOG_W-1:0]   level;
		logic [TXY_W-1:0]   tx;
		logic [TXY_W-1:0]   ty;
		logic [CHAIN_W-1:0] chain;
		rgb_t               color;
		logic               last;
	} result_t;

endpackage

// ===== hdl/mbf_row_mem.sv =====
// Single-port row store of horizontal pair sums, registered read.
module mbf_row_mem import mbf_pkg::*; (
	input  logic     clk,
	input  row_req_t req,
	output pair_t    rdata
);

	pair_t mem [ROW_DEPTH];

	// Write or read one entry per cycle
	always_ff @(posedge clk) begin
		if (req.en) begin
			if (req.we) begin
				mem[req.addr] <= req.wdata;
			end else begin
				rdata <= mem[req.addr];
			end
		end
	end

endmodule

// ===== hdl/mbf_frame.sv =====
// Size registers and level-0 raster position of the mipmap generator.
module mbf_frame import mbf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [LOG_W-1:0] cfg_data,
	input  logic             advance,
	output geom_t            geom,
	output logic [POS_W-1:0] pos_x,
	output logic [POS_W-1:0] pos_y
);

	localparam logic [LOG_W-1:0] MAX_L = LOG_W'(MAX_SIZE_LOG2);

	logic [LOG_W-1:0] wl_cfg_q, hl_cfg_q;
	logic [POS_W-1:0] x_q, y_q;
	logic [POS_W:0]   w_last, h_last;

	// Clamp oversized sizes and derive the level count
	always_comb begin
		geom.wl     = (wl_cfg_q > MAX_L) ? MAX_L : wl_cfg_q;
		geom.hl     = (hl_cfg_q > MAX_L) ? MAX_L : hl_cfg_q;
		geom.levels = (geom.wl < geom.hl) ? geom.wl : geom.hl;
		w_last      = ((POS_W+1)'(1) << geom.wl) - (POS_W+1)'(1);
		h_last      = ((POS_W+1)'(1) << geom.hl) - (POS_W+1)'(1);
	end

	// Hold sizes; restart the frame on any write, advance in raster order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_cfg_q <= MAX_L;
			hl_cfg_q <= MAX_L;
			x_q      <= '0;
			y_q      <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_WIDTH:  wl_cfg_q <= cfg_data;
				CFG_HEIGHT: hl_cfg_q <= cfg_data;
				default:    wl_cfg_q <= wl_cfg_q;
			endcase
			x_q <= '0;
			y_q <= '0;
		end else if (advance) begin
			if ({1'b0, x_q} >= w_last) begin
				x_q <= '0;
				y_q <= ({1'b0, y_q} >= h_last) ? '0 : y_q + POS_W'(1);
			end else begin
				x_q <= x_q + POS_W'(1);
			end
		end
	end

	assign pos_x = x_q;
	assign pos_y = y_q;

endmodule

// ===== hdl/mbf_engine.sv =====
// Level sequencer: pair holds, row store access and block averaging.
module mbf_engine import mbf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  geom_t            geom,
	input  logic [POS_W-1:0] pos_x,
	input  logic [POS_W-1:0] pos_y,
	input  logic             in_valid,
	output logic             in_ready,
	input  rgb_t             in_texel,
	output row_req_t         row_req,
	input  pair_t            row_rdata,
	output logic             out_valid,
	input  logic             out_ready,
	output result_t          result
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_STEP,
		S_EVAL
	} state_t;

	state_t             state_q;
	logic [LEV_W-1:0]   lev_q;
	logic               out_valid_q;
	result_t            result_q;

	rgb_t               cur_q;
	pair_t              pair_q;
	rgb_t               hold_q [MAX_SIZE_LOG2];
	logic [POS_W-1:0]   x_q, y_q;
	logic [CHAIN_W-1:0] chain_q;

	logic [POS_W-1:0]   lx, ly, lx_nx, ly_nx;
	logic [LEV_W-1:0]   lev_nx;
	logic [ROW_AW:0]    w_full, idx_sum;
	rgb_t               hold_rd;
	pair_t              pair;
	logic [SUM_W-1:0]   sum_r, sum_g, sum_b;
	rgb_t               avg;
	logic [LOG_W-1:0]   ty_shift;
	logic [CHAIN_W-1:0] wh_full, chain_step, chain_idx;
	logic               last;
	logic               fire;

	// Level coordinates, row store index and the running pair sum
	always_comb begin
		lx       = x_q >> lev_q;
		ly       = y_q >> lev_q;
		lev_nx   = lev_q + LEV_W'(1);
		lx_nx    = x_q >> lev_nx;
		ly_nx    = y_q >> lev_nx;
		w_full   = (ROW_AW+1)'(1) << geom.wl;
		idx_sum  = w_full - (w_full >> lev_q) + (ROW_AW+1)'(lx >> 1);
		hold_rd  = hold_q[lev_q];
		pair.r   = {1'b0, hold_rd.r} + {1'b0, cur_q.r};
		pair.g   = {1'b0, hold_rd.g} + {1'b0, cur_q.g};
		pair.b   = {1'b0, hold_rd.b} + {1'b0, cur_q.b};
	end

	// Round the block average and place the texel in the packed chain
	always_comb begin
		sum_r      = {2'b0, row_rdata.r} + {2'b0, pair_q.r} + SUM_W'(2);
		sum_g      = {2'b0, row_rdata.g} + {2'b0, pair_q.g} + SUM_W'(2);
		sum_b      = {2'b0, row_rdata.b} + {2'b0, pair_q.b} + SUM_W'(2);
		avg.r      = sum_r[CHANNEL_BITS+1:2];
		avg.g      = sum_g[CHANNEL_BITS+1:2];
		avg.b      = sum_b[CHANNEL_BITS+1:2];
		ty_shift   = geom.wl - LOG_W'(lev_q) - LOG_W'(1);
		chain_idx  = chain_q + CHAIN_W'(lx[POS_W-1:1])
			+ (CHAIN_W'(ly[POS_W-1:1]) << ty_shift);
		wh_full    = CHAIN_W'(1) << ({1'b0, geom.wl} + {1'b0, geom.hl});
		chain_step = wh_full >> {lev_nx, 1'b0};
		last       = (LOG_W'(lev_nx) == geom.levels) || !lx_nx[0] || !ly_nx[0];
		fire       = (state_q == S_EVAL) && (!out_valid_q || out_ready);
	end

	// Row store: store the upper row's pair, or fetch it for the lower row
	always_comb begin
		row_req.en    = (state_q == S_STEP) && lx[0];
		row_req.we    = !ly[0];
		row_req.addr  = idx_sum[ROW_AW-1:0];
		row_req.wdata = pair;
	end

	// Sequence levels and hold the output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			lev_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						lev_q <= '0;
						if (geom.levels != '0) begin
							state_q <= S_STEP;
						end
					end
				end
				S_STEP: begin
					state_q <= (lx[0] && ly[0]) ? S_EVAL : S_IDLE;
				end
				S_EVAL: begin
					// the next level still takes the averaged texel unless this is the top
					if (fire) begin
						if (LOG_W'(lev_nx) == geom.levels) begin
							state_q <= S_IDLE;
						end else begin
							lev_q   <= lev_nx;
							state_q <= S_STEP;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers: transaction capture, holds, pair and result
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			cur_q   <= in_texel;
			x_q     <= pos_x;
			y_q     <= pos_y;
			chain_q <= wh_full;
		end
		if (state_q == S_STEP) begin
			if (!lx[0]) begin
				hold_q[lev_q] <= cur_q;
			end
			pair_q <= pair;
		end
		if (fire) begin
			result_q.level <= LOG_W'(lev_nx);
			result_q.tx    <= lx[POS_W-1:1];
			result_q.ty    <= ly[POS_W-1:1];
			result_q.chain <= chain_idx;
			result_q.color <= avg;
			result_q.last  <= last;
			cur_q          <= avg;
			chain_q        <= chain_q + chain_step;
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign result    = result_q;

endmodule

// ===== hdl/mipmap_box_filter_generator_top.sv =====
// Streaming mipmap generator: level-0 RGB texels go in one per transaction in raster
// order, and every completed 2x2 block comes out as a rounded average one level up,
// cascading until the smaller dimension reaches one texel. Results of one input come
// in rising level order, the last flagged by last_of_run. An input is accepted only while
// the sequencer is idle: it then steps once per level reached, and a level that emits an
// average also waits for the output side before moving on. The row store of pair sums is
// a single-port memory with a registered read, read in the step before each average. A
// write to either size register restarts the frame.
module mipmap_box_filter_generator_top import mbf_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic                    cfg_index,
	input  logic [LOG_W-1:0]        cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [CHANNEL_BITS-1:0] red_in,
	input  logic [CHANNEL_BITS-1:0] green_in,
	input  logic [CHANNEL_BITS-1:0] blue_in,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [LOG_W-1:0]        mip_level,
	output logic [TXY_W-1:0]        texel_x,
	output logic [TXY_W-1:0]        texel_y,
	output logic [CHAIN_W-1:0]      chain_index,
	output logic [CHANNEL_BITS-1:0] red_out,
	output logic [CHANNEL_BITS-1:0] green_out,
	output logic [CHANNEL_BITS-1:0] blue_out,
	output logic                    last_of_run
);

`include "assert_macros.svh"

	geom_t            geom;
	logic [POS_W-1:0] pos_x, pos_y;
	rgb_t             in_texel;
	row_req_t         row_req;
	pair_t            row_rdata;
	result_t          result;

	assign in_texel = '{r: red_in, g: green_in, b: blue_in};

	mbf_frame u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.advance   (in_valid && in_ready),
		.geom      (geom),
		.pos_x     (pos_x),
		.pos_y     (pos_y)
	);

	mbf_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.geom      (geom),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_texel  (in_texel),
		.row_req   (row_req),
		.row_rdata (row_rdata),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.result    (result)
	);

	mbf_row_mem u_row_mem (
		.clk   (clk),
		.req   (row_req),
		.rdata (row_rdata)
	);

	// Break the result out onto its ports
	assign mip_level   = result.level;
	assign texel_x     = result.tx;
	assign texel_y     = result.ty;
	assign chain_index = result.chain;
	assign red_out     = result.color.r;
	assign green_out   = result.color.g;
	assign blue_out    = result.color.b;
	assign last_of_run = result.last;

	// A texel accepted into a frame with levels keeps the sequencer busy next cycle
	`MBF_ASSERT_NEXT(a_accept_busy, in_valid && in_ready && (geom.levels != '0), !in_ready, "input taken twice in a row")
	// While a non-final result waits, the rest of its run is still in flight
	`MBF_ASSERT(a_run_open, !(out_valid && !last_of_run && in_ready), "run ended without final flag")

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the streaming 2x2 box-filter mipmap generator.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import mbf_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 40;   // settle time before a register write and at the end
	localparam int LONG_HOLD     = 400;
	localparam int REPORT_LIMIT  = 100;

	// One row of the directed stimulus: a register write or a texel transaction.
	typedef struct packed {
		bit               is_cfg;
		logic             reg_sel;
		logic [LOG_W-1:0] reg_val;
		rgb_t             px;
		bit               typed;       // expected result written out in the row
		bit               has_result;
		result_t          res;
	} stim_row_t;

	logic                    clk;
	logic                    arst_n      = 1'b0;
	logic                    cfg_we      = 1'b0;
	logic                    cfg_index   = 1'b0;
	logic [LOG_W-1:0]        cfg_data    = '0;
	logic                    in_valid    = 1'b0;
	logic                    in_ready;
	logic [CHANNEL_BITS-1:0] red_in      = '0;
	logic [CHANNEL_BITS-1:0] green_in    = '0;
	logic [CHANNEL_BITS-1:0] blue_in     = '0;
	logic                    out_valid;
	logic                    out_ready   = 1'b0;
	logic [LOG_W-1:0]        mip_level;
	logic [TXY_W-1:0]        texel_x;
	logic [TXY_W-1:0]        texel_y;
	logic [CHAIN_W-1:0]      chain_index;
	logic [CHANNEL_BITS-1:0] red_out;
	logic [CHANNEL_BITS-1:0] green_out;
	logic [CHANNEL_BITS-1:0] blue_out;
	logic                    last_of_run;

	// Predictor copy of the configuration and the filter state.
	logic [LOG_W-1:0] width_log2_q  = 4'd10;
	logic [LOG_W-1:0] height_log2_q = 4'd10;
	int unsigned      col_pos       = 0;
	int unsigned      row_pos       = 0;
	rgb_t             left_hold [MAX_SIZE_LOG2];
	pair_t            pair_row  [ROW_DEPTH];

	result_t   texel_run[$];        // texels produced by the latest input
	result_t   expected_texels[$];  // texels still owed by the block
	stim_row_t stim_table[$];

	int mismatch_count = 0;
	int send_idle_pct  = 0;
	int recv_idle_pct  = 0;
	int hold_requests  = 0;

	mipmap_box_filter_generator_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.red_in      (red_in),
		.green_in    (green_in),
		.blue_in     (blue_in),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.mip_level   (mip_level),
		.texel_x     (texel_x),
		.texel_y     (texel_y),
		.chain_index (chain_index),
		.red_out     (red_out),
		.green_out   (green_out),
		.blue_out    (blue_out),
		.last_of_run (last_of_run)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	// End the run if the block hangs.
	initial begin : watchdog
		int cycles;
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles >= CYCLE_LIMIT) begin
				$display("timeout after %0d cycles, %0d texels pending", cycles,
					expected_texels.size());
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	function automatic rgb_t mk_rgb(input int r, input int g, input int b);
		rgb_t px;
		px.r = r;
		px.g = g;
		px.b = b;
		return px;
	endfunction

	function automatic result_t mk_result(input int lvl, input int x, input int y,
			input int chain, input int r, input int g, input int b);
		result_t res;
		res.level = lvl;
		res.tx    = x;
		res.ty    = y;
		res.chain = chain;
		res.color = mk_rgb(r, g, b);
		res.last  = 1'b1;
		return res;
	endfunction

	// Mix extremes into otherwise uniform channel values.
	function automatic chan_t rand_chan();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return chan_t'($urandom);
		endcase
	endfunction

	function automatic chan_t box_average(input pchan_t upper, input pchan_t lower);
		logic [SUM_W-1:0] total;
		total = upper + lower + 2;
		return chan_t'(total >> 2);
	endfunction

	// Walk one level-0 texel up the cascade; leave the produced texels in texel_run.
	task automatic predict_mip_texels(input rgb_t px);
		int unsigned wl, hl, levels, w, h, lx, ly, slot, chain_base, lv;
		rgb_t        cur;
		pair_t       pair;
		result_t     res;
		bit          done;
		texel_run.delete();
		wl     = (width_log2_q > MAX_SIZE_LOG2) ? MAX_SIZE_LOG2 : width_log2_q;
		hl     = (height_log2_q > MAX_SIZE_LOG2) ? MAX_SIZE_LOG2 : height_log2_q;
		levels = (wl < hl) ? wl : hl;
		w      = 1 << wl;
		h      = 1 << hl;
		cur        = px;
		chain_base = 0;
		done       = 1'b0;
		for (lv = 0; lv < levels && !done; lv++) begin
			lx = col_pos >> lv;
			ly = row_pos >> lv;
			slot = (w - (w >> lv) + (lx >> 1)) % ROW_DEPTH;
			chain_base += (w * h) >> (2 * lv);
			if (lx % 2 == 0) begin
				// hold the left texel of the pair
				left_hold[lv] = cur;
				done = 1'b1;
			end else begin
				pair.r = {1'b0, left_hold[lv].r} + {1'b0, cur.r};
				pair.g = {1'b0, left_hold[lv].g} + {1'b0, cur.g};
				pair.b = {1'b0, left_hold[lv].b} + {1'b0, cur.b};
				if (ly % 2 == 0) begin
					// store the upper pair sum for the next row
					pair_row[slot] = pair;
					done = 1'b1;
				end else begin
					cur.r = box_average(pair_row[slot].r, pair.r);
					cur.g = box_average(pair_row[slot].g, pair.g);
					cur.b = box_average(pair_row[slot].b, pair.b);
					res.level = lv + 1;
					res.tx    = lx >> 1;
					res.ty    = ly >> 1;
					res.chain = chain_base + (lx >> 1) + (ly >> 1) * (w >> (lv + 1));
					res.color = cur;
					res.last  = 1'b0;
					texel_run.push_back(res);
				end
			end
		end
		if (texel_run.size() > 0) begin
			res = texel_run.pop_back();
			res.last = 1'b1;
			texel_run.push_back(res);
		end
		// advance the raster position, wrap at frame end
		col_pos++;
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos++;
			if (row_pos >= h)
				row_pos = 0;
		end
	endtask

	task automatic report_mismatch(input string what, input longint got, input longint want);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT)
			$display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	task automatic check_result();
		result_t want;
		if (expected_texels.size() == 0) begin
			report_mismatch("result with nothing pending, mip_level", mip_level, 0);
			return;
		end
		want = expected_texels.pop_front();
		if (mip_level !== want.level)
			report_mismatch("mip_level", mip_level, want.level);
		if (texel_x !== want.tx)
			report_mismatch("texel_x", texel_x, want.tx);
		if (texel_y !== want.ty)
			report_mismatch("texel_y", texel_y, want.ty);
		if (chain_index !== want.chain)
			report_mismatch("chain_index", chain_index, want.chain);
		if (red_out !== want.color.r)
			report_mismatch("red_out", red_out, want.color.r);
		if (green_out !== want.color.g)
			report_mismatch("green_out", green_out, want.color.g);
		if (blue_out !== want.color.b)
			report_mismatch("blue_out", blue_out, want.color.b);
		if (last_of_run !== want.last)
			report_mismatch("last_of_run", last_of_run, want.last);
	endtask

	// Accept results, stall at random, and serve long hold-off requests.
	initial begin : result_sink
		int hold_left;
		int holds_served;
		hold_left    = 0;
		holds_served = 0;
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_ready)
				check_result();
			if (hold_left == 0 && holds_served < hold_requests) begin
				hold_left = LONG_HOLD;
				holds_served++;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	task automatic set_idling(input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		recv_idle_pct <= recv_pct;
	endtask

	// Drain the block, then write one size register.
	task automatic write_reg(input logic sel, input int val);
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_texels.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= sel;
		cfg_data  <= val[LOG_W-1:0];
		@(posedge clk);
		if (sel == CFG_WIDTH)
			width_log2_q = val[LOG_W-1:0];
		else
			height_log2_q = val[LOG_W-1:0];
		col_pos = 0;
		row_pos = 0;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Offer one texel transaction and queue what it should produce.
	task automatic drive_texel(input rgb_t px, input bit typed, input bit has_result,
			input result_t res);
		int k;
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		red_in   <= px.r;
		green_in <= px.g;
		blue_in  <= px.b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_mip_texels(px);
		if (typed) begin
			if (has_result)
				expected_texels.push_back(res);
		end else begin
			for (k = 0; k < texel_run.size(); k++)
				expected_texels.push_back(texel_run[k]);
		end
	endtask

	task automatic run_phase(input int wl, input int hl, input int count, input bit hold);
		write_reg(CFG_WIDTH, wl);
		write_reg(CFG_HEIGHT, hl);
		if (hold)
			hold_requests <= hold_requests + 1;
		repeat (count)
			drive_texel(mk_rgb(rand_chan(), rand_chan(), rand_chan()), 1'b0, 1'b0, '0);
	endtask

	function automatic void row_cfg(input logic sel, input int val);
		stim_row_t row;
		row = '0;
		row.is_cfg  = 1'b1;
		row.reg_sel = sel;
		row.reg_val = val;
		stim_table.push_back(row);
	endfunction

	function automatic void row_texel(input rgb_t px, input bit typed, input bit has_result,
			input result_t res);
		stim_row_t row;
		row = '0;
		row.px         = px;
		row.typed      = typed;
		row.has_result = has_result;
		row.res        = res;
		stim_table.push_back(row);
	endfunction

	initial begin : stimulus
		int i;
		// after reset the frame is 1024x1024, so a lone texel completes nothing
		row_texel(mk_rgb('hFFFF, 0, 'hFFFF), 1'b1, 1'b0, '0);
		// 2x2 frame at full scale
		row_cfg(CFG_WIDTH, 1);
		row_cfg(CFG_HEIGHT, 1);
		for (i = 0; i < 3; i++)
			row_texel(mk_rgb('hFFFF, 'hFFFF, 'hFFFF), 1'b1, 1'b0, '0);
		row_texel(mk_rgb('hFFFF, 'hFFFF, 'hFFFF), 1'b1, 1'b1,
			mk_result(1, 0, 0, 4, 'hFFFF, 'hFFFF, 'hFFFF));
		// next frame: rounding below half, at a tie, and above half
		row_texel(mk_rgb(0, 0, 1), 1'b1, 1'b0, '0);
		row_texel(mk_rgb(0, 0, 1), 1'b1, 1'b0, '0);
		row_texel(mk_rgb(0, 1, 1), 1'b1, 1'b0, '0);
		row_texel(mk_rgb(1, 1, 0), 1'b1, 1'b1, mk_result(1, 0, 0, 4, 0, 1, 1));
		// single row, then single column: no level at all
		row_cfg(CFG_HEIGHT, 0);
		row_texel(mk_rgb('hFFFF, 'hFFFF, 'hFFFF), 1'b1, 1'b0, '0);
		row_cfg(CFG_WIDTH, 0);
		row_cfg(CFG_HEIGHT, 3);
		row_texel(mk_rgb('hFFFF, 0, 0), 1'b1, 1'b0, '0);
		// oversized height clamps to the largest size
		row_cfg(CFG_WIDTH, 1);
		row_cfg(CFG_HEIGHT, 15);
		row_texel(mk_rgb('h1234, 'hFFFF, 'h0001), 1'b0, 1'b0, '0);
		row_texel(mk_rgb('h8000, 'hFFFE, 'h7FFF), 1'b0, 1'b0, '0);
		row_texel(mk_rgb('h0003, 'hAAAA, 'h5555), 1'b0, 1'b0, '0);
		row_texel(mk_rgb('hFFFF, 'h0000, 'hC0DE), 1'b0, 1'b0, '0);

		wait (arst_n === 1'b1);
		@(posedge clk);

		// sender idles rarely, receiver often
		set_idling(18, 79);
		for (i = 0; i < stim_table.size(); i++) begin
			if (stim_table[i].is_cfg)
				write_reg(stim_table[i].reg_sel, stim_table[i].reg_val);
			else
				drive_texel(stim_table[i].px, stim_table[i].typed,
					stim_table[i].has_result, stim_table[i].res);
		end
		run_phase(1, 1, 12, 1'b0);
		run_phase(2, 3, 16, 1'b0);
		run_phase(1, 12, 12, 1'b0);

		// sender idles often, receiver rarely
		set_idling(79, 18);
		run_phase(10, 10, 4, 1'b0);
		run_phase(0, 0, 4, 1'b0);
		run_phase(2, 0, 4, 1'b0);
		run_phase(4, 4, 8, 1'b0);

		// no idling; one long receiver hold-off fills the block
		set_idling(0, 0);
		run_phase(3, 3, 36, 1'b1);
		run_phase(15, 1, 8, 1'b0);

		// drain and settle
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_texels.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
